/* src/tssvb_pkg.sv */
// Shared constants, widths and types for the two-stage state-variable band-pass core.
// No dependencies; imported by tssvb_mac and the top level.
package tssvb_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STATE_BITS  = 48;
  localparam int COEF_BITS   = 32;
  localparam int FRAC_BITS   = 24;

  // state word is split into a low fraction part and a signed upper part
  localparam int HI_BITS   = STATE_BITS - FRAC_BITS;
  localparam int OPB_BITS  = (HI_BITS > FRAC_BITS) ? HI_BITS : FRAC_BITS + 1;
  localparam int PROD_BITS = COEF_BITS + OPB_BITS;
  localparam int TAIL_BITS = PROD_BITS - FRAC_BITS;

  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_DAMPING  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_OMEGA_SQ = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_ATTEN    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_DAMP1,
    OP_OMEGA1,
    OP_DAMP2,
    OP_OMEGA2,
    OP_ATTEN
  } op_e;

  typedef struct packed {
    logic lo_en;
    logic hi_en;
  } mac_ctl_t;

endpackage

/* src/tssvb_mac.sv */
// Shared multiply unit: coef * state over two passes (low fraction, then upper part).
// Depends on tssvb_pkg. acc_o = floor(coef * opnd / 2^FRAC_BITS), full width.
module tssvb_mac import tssvb_pkg::*; (
  input  logic                        clk_i,
  input  mac_ctl_t                    ctl_i,
  input  logic signed [COEF_BITS-1:0] coef_i,
  input  logic signed [STATE_BITS-1:0] opnd_i,
  output logic signed [PROD_BITS-1:0] acc_o
);

  logic signed [OPB_BITS-1:0]  b;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] p_q;
  logic signed [TAIL_BITS-1:0] t_q;

  always_comb begin
    if (ctl_i.lo_en) begin
      b = signed'({{(OPB_BITS-FRAC_BITS){1'b0}}, opnd_i[FRAC_BITS-1:0]});
    end else begin
      b = OPB_BITS'(signed'(opnd_i[STATE_BITS-1:FRAC_BITS]));
    end
  end

  assign prod = coef_i * b;

  // low pass product is parked, shifted, while the upper product is formed
  always_ff @(posedge clk_i) begin
    if (ctl_i.lo_en) begin
      p_q <= prod;
    end
    if (ctl_i.hi_en) begin
      p_q <= prod;
      t_q <= p_q[PROD_BITS-1:FRAC_BITS];
    end
  end

  assign acc_o = p_q + PROD_BITS'(t_q);

endmodule

/* src/two_stage_state_variable_bandpass_core.sv */
// Two cascaded state-variable sections; section two's high term, scaled, is the output.
// A new item is stalled until the previous one has left OUT; one shared multiplier forms all 10 partial products.
// Reset: async active low; coefficients and all four integrators clear to zero.
// Depends on tssvb_pkg and tssvb_mac.
module two_stage_state_variable_bandpass_core import tssvb_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [REG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [COEF_BITS-1:0]          cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          clipped_o
);

  localparam logic signed [TAIL_BITS-1:0] R_MAX = TAIL_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [TAIL_BITS-1:0] R_MIN = ~R_MAX;

  // coefficients
  logic signed [COEF_BITS-1:0] damp_q, omega_q, atten_q;

  // integrators and scratch
  logic signed [STATE_BITS-1:0] low1_q, band1_q, low2_q, band2_q;
  logic signed [STATE_BITS-1:0] low1_d, band1_d, low2_d, band2_d;
  logic signed [STATE_BITS-1:0] x_q, h_q, h_d;

  // sequencer
  state_e state_q, state_d;
  op_e    op_q, op_d;

  // control outputs
  mac_ctl_t mac_ctl;
  logic     accept, acc_en, out_free, out_load;

  // shared unit
  logic signed [COEF_BITS-1:0]  coef_sel;
  logic signed [STATE_BITS-1:0] opnd_sel;
  logic signed [PROD_BITS-1:0]  acc;
  logic signed [STATE_BITS-1:0] m;

  // output formatting
  logic signed [TAIL_BITS-1:0]   r;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          clip;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic                          clipped_q;

  // ---------------------------------------------------------------------------
  // Sequencer: each product takes LO, HI, ACC; the final scaling skips ACC
  // and goes to OUT, where the result waits for the output register.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LO;
          op_d    = OP_DAMP1;
        end
      end
      ST_LO: state_d = ST_HI;
      ST_HI: begin
        state_d = (op_q == OP_ATTEN) ? ST_OUT : ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_LO;
        op_d    = op_e'(op_q + 3'd1);
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    accept        = (state_q == ST_IDLE) && in_valid_i;
    mac_ctl.lo_en = (state_q == ST_LO);
    mac_ctl.hi_en = (state_q == ST_HI);
    acc_en        = (state_q == ST_ACC);
    out_load      = (state_q == ST_OUT) && out_free;
  end

  // ---------------------------------------------------------------------------
  // Operand selection for the shared multiplier
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (op_q)
      OP_DAMP1: begin
        coef_sel = damp_q;
        opnd_sel = band1_q;
      end
      OP_DAMP2: begin
        coef_sel = damp_q;
        opnd_sel = band2_q;
      end
      OP_OMEGA1, OP_OMEGA2: begin
        coef_sel = omega_q;
        opnd_sel = h_q;
      end
      OP_ATTEN: begin
        coef_sel = atten_q;
        opnd_sel = h_q;
      end
      default: begin
        coef_sel = damp_q;
        opnd_sel = h_q;
      end
    endcase
  end

  tssvb_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .coef_i (coef_sel),
    .opnd_i (opnd_sel),
    .acc_o  (acc)
  );

  // low STATE_BITS of the floored product: the wrapped mulq term
  assign m = acc[STATE_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Integrator updates, one per ACC step
  //   DAMP1 : high1 = x - d*band1 - low1
  //   OMEGA1: band1 += w*high1, low1 += band1
  //   DAMP2 : high2 = low1 - d*band2 - low2
  //   OMEGA2: band2 += w*high2, low2 += band2
  // h_q keeps high2 through the scaling pass.
  // ---------------------------------------------------------------------------
  always_comb begin
    h_d     = h_q;
    band1_d = band1_q;
    low1_d  = low1_q;
    band2_d = band2_q;
    low2_d  = low2_q;
    unique case (op_q)
      OP_DAMP1:  h_d = x_q - m - low1_q;
      OP_OMEGA1: begin
        band1_d = band1_q + m;
        low1_d  = low1_q + band1_q + m;
      end
      OP_DAMP2:  h_d = low1_q - m - low2_q;
      OP_OMEGA2: begin
        band2_d = band2_q + m;
        low2_d  = low2_q + band2_q + m;
      end
      OP_ATTEN:  h_d = h_q;
      default:   h_d = h_q;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output: floor(atten * high2 / 2^48), saturated to the sample range
  // ---------------------------------------------------------------------------
  assign r = acc[PROD_BITS-1:FRAC_BITS];

  always_comb begin
    priority if (r > R_MAX) begin
      sat  = R_MAX[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else if (r < R_MIN) begin
      sat  = R_MIN[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else begin
      sat  = r[SAMPLE_BITS-1:0];
      clip = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DAMP1;
      out_valid_q <= 1'b0;
      damp_q      <= '0;
      omega_q     <= '0;
      atten_q     <= '0;
      low1_q      <= '0;
      band1_q     <= '0;
      low2_q      <= '0;
      band2_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_DAMPING:  damp_q  <= cfg_data_i;
          REG_OMEGA_SQ: omega_q <= cfg_data_i;
          REG_ATTEN:    atten_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc_en) begin
        low1_q  <= low1_d;
        band1_q <= band1_d;
        low2_q  <= low2_d;
        band2_q <= band2_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= STATE_BITS'(signed'({sample_in_i, {FRAC_BITS{1'b0}}}));
    end
    if (acc_en) begin
      h_q <= h_d;
    end
    if (out_load) begin
      sample_out_q <= sat;
      clipped_q    <= clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule
